@@ rtl/morse_code_char_encoder_assert.svh @@
// Assertion macros for the Morse encoder
`ifndef MORSE_CODE_CHAR_ENCODER_ASSERT_SVH
`define MORSE_CODE_CHAR_ENCODER_ASSERT_SVH

// check a property on clk, off while rst_n is low
`define MCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on clk at every edge, reset included
`define MCE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mce_pkg.sv @@
package mce_pkg;

  localparam int RomSize = 26;
  localparam int CodeMax = 6;

  localparam logic [1:0] SYM_DOT   = 2'd0;
  localparam logic [1:0] SYM_DASH  = 2'd1;
  localparam logic [1:0] SYM_SLASH = 2'd2;
  localparam logic [1:0] SYM_GAP   = 2'd3;

  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // residues of 'a' and '0' modulo 26
  localparam logic [5:0] LO_A_RES = 6'(97 % RomSize);
  localparam logic [5:0] ZERO_RES = 6'(48 % RomSize);
  localparam logic [5:0] ROM_MOD  = 6'(RomSize);

  localparam logic [4:0] IDX_DOT   = 5'(46 % RomSize);
  localparam logic [4:0] IDX_COMMA = 5'(44 % RomSize);
  localparam logic [4:0] IDX_QUEST = 5'(63 % RomSize);
  localparam logic [4:0] IDX_SPACE = 5'(32 % RomSize);

  typedef logic [4:0] rom_idx_t;
  typedef logic [2:0] len_t;

  // dash mask is left aligned: bit 5 is the first symbol
  typedef struct packed {
    len_t       len;
    logic [5:0] dash;
    logic       slash;
  } code_t;

  typedef struct packed {
    len_t                      len;
    logic [CodeMax-1:0][1:0]   sym;
    logic                      gap;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    len_t idx;
  } bk_stat_t;

  function automatic code_t rom_alpha(rom_idx_t idx);
    code_t c;
    unique case (idx)
      5'd0:    c = '{len: 3'd4, dash: 6'b000000, slash: 1'b0};
      5'd1:    c = '{len: 3'd2, dash: 6'b000000, slash: 1'b0};
      5'd2:    c = '{len: 3'd4, dash: 6'b011100, slash: 1'b0};
      5'd3:    c = '{len: 3'd3, dash: 6'b101000, slash: 1'b0};
      5'd4:    c = '{len: 3'd4, dash: 6'b010000, slash: 1'b0};
      5'd5:    c = '{len: 3'd2, dash: 6'b110000, slash: 1'b0};
      5'd6:    c = '{len: 3'd2, dash: 6'b100000, slash: 1'b0};
      5'd7:    c = '{len: 3'd3, dash: 6'b111000, slash: 1'b0};
      5'd8:    c = '{len: 3'd4, dash: 6'b011000, slash: 1'b0};
      5'd9:    c = '{len: 3'd4, dash: 6'b110100, slash: 1'b0};
      5'd10:   c = '{len: 3'd3, dash: 6'b010000, slash: 1'b0};
      5'd11:   c = '{len: 3'd3, dash: 6'b000000, slash: 1'b0};
      5'd12:   c = '{len: 3'd1, dash: 6'b100000, slash: 1'b0};
      5'd13:   c = '{len: 3'd3, dash: 6'b001000, slash: 1'b0};
      5'd14:   c = '{len: 3'd4, dash: 6'b000100, slash: 1'b0};
      5'd15:   c = '{len: 3'd3, dash: 6'b011000, slash: 1'b0};
      5'd16:   c = '{len: 3'd4, dash: 6'b100100, slash: 1'b0};
      5'd17:   c = '{len: 3'd4, dash: 6'b101100, slash: 1'b0};
      5'd18:   c = '{len: 3'd4, dash: 6'b110000, slash: 1'b0};
      5'd19:   c = '{len: 3'd2, dash: 6'b010000, slash: 1'b0};
      5'd20:   c = '{len: 3'd4, dash: 6'b100000, slash: 1'b0};
      5'd21:   c = '{len: 3'd4, dash: 6'b101000, slash: 1'b0};
      5'd22:   c = '{len: 3'd3, dash: 6'b100000, slash: 1'b0};
      5'd23:   c = '{len: 3'd1, dash: 6'b000000, slash: 1'b0};
      5'd24:   c = '{len: 3'd4, dash: 6'b001000, slash: 1'b0};
      5'd25:   c = '{len: 3'd3, dash: 6'b110000, slash: 1'b0};
      default: c = '{len: 3'd0, dash: 6'b000000, slash: 1'b0};
    endcase
    return c;
  endfunction

  // digit zero sits at 22 as five dashes
  function automatic code_t rom_numpunct(rom_idx_t idx);
    code_t c;
    unique case (idx)
      5'd0:    c = '{len: 3'd5, dash: 6'b000010, slash: 1'b0};
      5'd1:    c = '{len: 3'd5, dash: 6'b000000, slash: 1'b0};
      5'd2:    c = '{len: 3'd5, dash: 6'b100000, slash: 1'b0};
      5'd3:    c = '{len: 3'd5, dash: 6'b110000, slash: 1'b0};
      5'd4:    c = '{len: 3'd5, dash: 6'b111000, slash: 1'b0};
      5'd5:    c = '{len: 3'd5, dash: 6'b111100, slash: 1'b0};
      5'd6:    c = '{len: 3'd1, dash: 6'b000000, slash: 1'b1};
      5'd11:   c = '{len: 3'd6, dash: 6'b001100, slash: 1'b0};
      5'd18:   c = '{len: 3'd6, dash: 6'b110011, slash: 1'b0};
      5'd20:   c = '{len: 3'd6, dash: 6'b010101, slash: 1'b0};
      5'd22:   c = '{len: 3'd5, dash: 6'b111110, slash: 1'b0};
      5'd23:   c = '{len: 3'd5, dash: 6'b011110, slash: 1'b0};
      5'd24:   c = '{len: 3'd5, dash: 6'b001110, slash: 1'b0};
      5'd25:   c = '{len: 3'd5, dash: 6'b000110, slash: 1'b0};
      default: c = '{len: 3'd0, dash: 6'b000000, slash: 1'b0};
    endcase
    return c;
  endfunction

endpackage

@@ rtl/mce_front.sv @@
module mce_front
  import mce_pkg::*;
(
  input  logic [7:0] in_char_code,
  input  logic       in_final_char,
  output cmd_t       cmd,
  output logic       cmd_nonempty
);

  logic [7:0] fold_c;
  logic       is_alpha;
  logic       is_digit;
  logic       is_punct;
  logic [7:0] ofs;
  logic [5:0] sum;
  rom_idx_t   idx;
  rom_idx_t   p_idx;
  code_t      code;

  always_comb begin
    fold_c = in_char_code;
    if (in_char_code >= CH_UP_A && in_char_code <= CH_UP_Z) begin
      fold_c = in_char_code + CASE_OFS;
    end
    is_alpha = (fold_c >= CH_LO_A) && (fold_c <= CH_LO_Z);
    is_digit = (fold_c >= CH_ZERO) && (fold_c <= CH_NINE);
    is_punct = (fold_c == CH_DOT) || (fold_c == CH_COMMA) ||
               (fold_c == CH_QUEST) || (fold_c == CH_SPACE);
  end

  // code modulo 26: offset from the range base plus the base residue, one wrap
  always_comb begin
    ofs = is_alpha ? (fold_c - CH_LO_A) : (fold_c - CH_ZERO);
    sum = {1'b0, ofs[4:0]} + (is_alpha ? LO_A_RES : ZERO_RES);
    if (sum >= ROM_MOD) begin
      sum = sum - ROM_MOD;
    end
    priority if (fold_c == CH_DOT) begin
      p_idx = IDX_DOT;
    end else if (fold_c == CH_COMMA) begin
      p_idx = IDX_COMMA;
    end else if (fold_c == CH_QUEST) begin
      p_idx = IDX_QUEST;
    end else begin
      p_idx = IDX_SPACE;
    end
    idx = is_punct ? p_idx : sum[4:0];
  end

  always_comb begin
    priority if (is_alpha) begin
      code = rom_alpha(idx);
    end else if (is_digit || is_punct) begin
      code = rom_numpunct(idx);
    end else begin
      code = '{len: 3'd0, dash: 6'b000000, slash: 1'b0};
    end
  end

  always_comb begin
    cmd.len = code.len;
    cmd.gap = !in_final_char;
    for (int k = 0; k < CodeMax; k++) begin
      if (code.slash) begin
        cmd.sym[k] = SYM_SLASH;
      end else if (code.dash[CodeMax-1-k]) begin
        cmd.sym[k] = SYM_DASH;
      end else begin
        cmd.sym[k] = SYM_DOT;
      end
    end
    cmd_nonempty = (code.len != 3'd0) || !in_final_char;
  end

endmodule

@@ rtl/mce_queue.sv @@
module mce_queue
  import mce_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output logic    head_valid,
  output cmd_t    head_cmd,
  output q_stat_t stat
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign head_valid = !stat.empty;
  assign head_cmd   = mem_r[rd_ptr_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ rtl/mce_back.sv @@
module mce_back
  import mce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_symbol,
  output logic       out_run_end,
  output bk_stat_t   stat
);

  len_t       idx_r;
  len_t       idx_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [1:0] symbol_r;
  logic [1:0] symbol_nxt;
  logic       run_end_r;
  logic       run_end_nxt;
  len_t       total;
  logic       is_last;
  logic       fire;

  always_comb begin
    total   = head_cmd.len + {2'b00, head_cmd.gap};
    is_last = (idx_r == total - 3'd1);
    fire    = head_valid && (!out_valid_r || out_ready);
    pop     = fire && is_last;

    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    symbol_nxt    = symbol_r;
    run_end_nxt   = run_end_r;
    if (fire) begin
      idx_nxt       = is_last ? 3'd0 : idx_r + 3'd1;
      out_valid_nxt = 1'b1;
      symbol_nxt    = (idx_r < head_cmd.len) ? head_cmd.sym[idx_r] : SYM_GAP;
      run_end_nxt   = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    symbol_r  <= symbol_nxt;
    run_end_r <= run_end_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_symbol  = symbol_r;
  assign out_run_end = run_end_r;
  assign stat.busy   = head_valid;
  assign stat.idx    = idx_r;

endmodule

@@ rtl/morse_code_char_encoder.sv @@
// channel   ports                                     direction
// in        in_valid in_ready in_char_code in_final_char  into block
// out       out_valid out_ready out_symbol out_run_end    out of block
//
// One symbol leaves per cycle unless out_ready stalls or the queue is empty;
// a character yields 1 to 7 symbols (code length plus one gap unless final),
// set by the back-end serializer. Characters with no symbols are taken and dropped.
// A two-entry queue parts front and back; in_ready drops only when it is full.
// rst_n is synchronous and clears the queue, the serializer and out_valid.
// A stalled out_ready holds the output register and backs up into the queue.
`include "morse_code_char_encoder_assert.svh"

module morse_code_char_encoder
  import mce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_final_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_symbol,
  output logic       out_run_end
);

  cmd_t     f_cmd;
  logic     f_nonempty;
  logic     q_push;
  logic     q_pop;
  logic     q_head_valid;
  cmd_t     q_head_cmd;
  q_stat_t  q_stat;
  bk_stat_t b_stat;

  mce_front u_front (
    .in_char_code  (in_char_code),
    .in_final_char (in_final_char),
    .cmd           (f_cmd),
    .cmd_nonempty  (f_nonempty)
  );

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready && f_nonempty;

  mce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (f_cmd),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .stat       (q_stat)
  );

  mce_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (q_head_valid),
    .head_cmd    (q_head_cmd),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_symbol  (out_symbol),
    .out_run_end (out_run_end),
    .stat        (b_stat)
  );

  `MCE_ASSERT(a_q_stat, !(q_stat.full && q_stat.empty), "queue full and empty")
  `MCE_ASSERT(a_idx_range, b_stat.idx <= 3'(CodeMax), "serializer index past code")
  `MCE_ASSERT(a_gap_last, out_valid && out_symbol == SYM_GAP |-> out_run_end, "gap not last")
  `MCE_ASSERT(a_idle_idx, !b_stat.busy |-> b_stat.idx == 3'd0, "index held while idle")

endmodule
